### sv/mpq_pkg.sv
// Package for the multilevel priority queue: sizes, request and status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    localparam int MAX_LEVELS   = 8;
    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 16;

    localparam int REQ_W    = 2;
    localparam int PRI_W    = 8;
    localparam int RUN_W    = 8;
    localparam int CFG_W    = 4;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_NEXT   = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_IGNORE = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_NOINIT  = 3'd1,
        STS_BADPRI  = 3'd2,
        STS_NONE    = 3'd3,
        STS_ZEROPOS = 3'd4,
        STS_FULL    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SUM,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_RM_RD,
        S_RM_TAKE,
        S_RM_CHK,
        S_RM_NRD,
        S_RM_WR,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RD_CUR,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    latch_code;
        logic    acc_init;
        logic    acc_step;
        logic    idx_load_total;
        logic    idx_load_rm;
        logic    idx_dec;
        logic    idx_inc;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    wr_shift;
        logic    wr_new;
        logic    take;
        logic    add_commit;
        logic    rm_commit;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic proceed;
        logic is_add;
        logic lvl_last;
        logic at_pos;
        logic rm_end;
    } dp_sts_t;

endpackage

`default_nettype wire

### sv/mpq_ctrl.sv
// Controller FSM of the multilevel priority queue: sequences decode, level sum,
// store shifting and result delivery. Depends on mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mpq_pkg::dp_sts_t  sts,
    output logic                   busy,
    output mpq_pkg::dp_cmd_t       cmd
);

    mpq_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = mpq_pkg::S_DECIDE;
                end
            end
            mpq_pkg::S_DECIDE:
            begin
                priority if (!sts.proceed)
                begin
                    state_next = mpq_pkg::S_FINISH;
                end
                else if (sts.is_add)
                begin
                    state_next = mpq_pkg::S_SUM;
                end
                else
                begin
                    state_next = mpq_pkg::S_RM_RD;
                end
            end
            mpq_pkg::S_SUM:
            begin
                if (sts.lvl_last)
                begin
                    state_next = mpq_pkg::S_INS_CHK;
                end
            end
            mpq_pkg::S_INS_CHK:
            begin
                state_next = sts.at_pos ? mpq_pkg::S_INS_PUT : mpq_pkg::S_INS_RD;
            end
            mpq_pkg::S_INS_RD:  state_next = mpq_pkg::S_INS_WR;
            mpq_pkg::S_INS_WR:  state_next = mpq_pkg::S_INS_CHK;
            mpq_pkg::S_INS_PUT: state_next = mpq_pkg::S_FINISH;
            mpq_pkg::S_RM_RD:   state_next = mpq_pkg::S_RM_TAKE;
            mpq_pkg::S_RM_TAKE: state_next = mpq_pkg::S_RM_CHK;
            mpq_pkg::S_RM_CHK:
            begin
                state_next = sts.rm_end ? mpq_pkg::S_FINISH : mpq_pkg::S_RM_NRD;
            end
            mpq_pkg::S_RM_NRD:  state_next = mpq_pkg::S_RM_WR;
            mpq_pkg::S_RM_WR:   state_next = mpq_pkg::S_RM_CHK;
            mpq_pkg::S_FINISH:  state_next = mpq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = mpq_pkg::RD_CUR;
        busy       = (state_reg != mpq_pkg::S_IDLE);
        unique case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                cmd.capture = start;
            end
            mpq_pkg::S_DECIDE:
            begin
                cmd.latch_code  = 1'b1;
                cmd.acc_init    = sts.proceed && sts.is_add;
                cmd.idx_load_rm = sts.proceed && !sts.is_add;
            end
            mpq_pkg::S_SUM:
            begin
                cmd.acc_step       = 1'b1;
                cmd.idx_load_total = sts.lvl_last;
            end
            mpq_pkg::S_INS_CHK:
            begin
            end
            mpq_pkg::S_INS_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = mpq_pkg::RD_PREV;
            end
            mpq_pkg::S_INS_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
            end
            mpq_pkg::S_INS_PUT:
            begin
                cmd.wr_new     = 1'b1;
                cmd.add_commit = 1'b1;
            end
            mpq_pkg::S_RM_RD:
            begin
                cmd.mem_rd = 1'b1;
            end
            mpq_pkg::S_RM_TAKE:
            begin
                cmd.take = 1'b1;
            end
            mpq_pkg::S_RM_CHK:
            begin
                cmd.rm_commit = sts.rm_end;
            end
            mpq_pkg::S_RM_NRD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = mpq_pkg::RD_NEXT;
            end
            mpq_pkg::S_RM_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            mpq_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
            end
        endcase
    end

    a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == mpq_pkg::S_DECIDE))
        else $error("accepted request did not enter decode");

endmodule

`default_nettype wire

### sv/mpq_datapath.sv
// Datapath of the multilevel priority queue: request registers, level counts,
// ordered entry store (one read, one write port) and result registers. Depends on mpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpq_datapath #(
    parameter int MAX_LEVELS = mpq_pkg::MAX_LEVELS,
    parameter int CAPACITY   = mpq_pkg::CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mpq_pkg::dp_cmd_t                  cmd,
    output mpq_pkg::dp_sts_t                       sts,
    input  wire logic [mpq_pkg::REQ_W-1:0]         req_type,
    input  wire logic [mpq_pkg::PRI_W-1:0]         priority_req,
    input  wire logic [mpq_pkg::PAYLOAD_BITS-1:0]  payload,
    input  wire logic [mpq_pkg::RUN_W-1:0]         running_number,
    input  wire logic                              cfg_we,
    input  wire logic [mpq_pkg::CFG_W-1:0]         cfg_data,
    output logic                                   done,
    output logic [mpq_pkg::STATUS_W-1:0]           status,
    output logic [mpq_pkg::PAYLOAD_BITS-1:0]       payload_out,
    output logic [mpq_pkg::TOTAL_W-1:0]            entry_total
);

    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LVW = $clog2(MAX_LEVELS + 1);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int PW  = mpq_pkg::PAYLOAD_BITS;
    localparam int MW  = LW + PW;
    localparam int TW  = mpq_pkg::TOTAL_W;

    mpq_pkg::req_t            req_reg;
    logic [mpq_pkg::PRI_W-1:0] pri_reg;
    logic [PW-1:0]             pay_reg;
    logic [mpq_pkg::RUN_W-1:0] run_reg;

    logic [LVW-1:0] levels_reg, levels_next;
    logic [CW-1:0]  total_reg, total_next;
    logic [CW-1:0]  cnt_reg [MAX_LEVELS];
    logic [CW-1:0]  cnt_next [MAX_LEVELS];
    logic [CW-1:0]  acc_reg, acc_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [LW-1:0]  lidx_reg, lidx_next;
    mpq_pkg::status_t code_reg, code_next, code_now;
    logic [PW-1:0]  taken_reg, taken_next;

    logic               done_reg;
    mpq_pkg::status_t   status_reg;
    logic [PW-1:0]      pay_out_reg, pay_out_next;
    logic [TW-1:0]      tot_out_reg;

    logic [MW-1:0] mem [CAPACITY];
    logic [MW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [MW-1:0] mem_wd;

    logic          cfg_load;
    logic [31:0]   cfg32, sat32, pri_m1, lev_m1, run_m1, ra32;
    logic [LW-1:0] pri_lvl, rd_lvl;
    logic [CW+TW-1:0] tot_ext;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= mpq_pkg::req_t'(req_type);
            pri_reg <= priority_req;
            pay_reg <= payload;
            run_reg <= running_number;
        end
    end

    assign pri_m1  = 32'(pri_reg) - 32'd1;
    assign lev_m1  = 32'(levels_reg) - 32'd1;
    assign run_m1  = 32'(run_reg) - 32'd1;
    assign pri_lvl = pri_m1[LW-1:0];
    assign rd_lvl  = rd_data_reg[MW-1:PW];

    assign cfg_load = cfg_we && (cfg_data != '0);
    assign cfg32    = 32'(cfg_data);
    assign sat32    = (cfg32 > 32'(MAX_LEVELS)) ? 32'(MAX_LEVELS) : cfg32;

    always_comb
    begin
        code_now = mpq_pkg::STS_OK;
        priority if (req_reg == mpq_pkg::REQ_IGNORE)
        begin
            code_now = mpq_pkg::STS_OK;
        end
        else if (levels_reg == '0)
        begin
            code_now = mpq_pkg::STS_NOINIT;
        end
        else
        begin
            unique case (req_reg)
                mpq_pkg::REQ_ADD:
                begin
                    priority if (pri_reg == '0 || 32'(pri_reg) > 32'(levels_reg))
                    begin
                        code_now = mpq_pkg::STS_BADPRI;
                    end
                    else if (32'(total_reg) >= 32'(CAPACITY))
                    begin
                        code_now = mpq_pkg::STS_FULL;
                    end
                    else
                    begin
                        code_now = mpq_pkg::STS_OK;
                    end
                end
                mpq_pkg::REQ_NEXT:
                begin
                    if (total_reg == '0)
                    begin
                        code_now = mpq_pkg::STS_NONE;
                    end
                end
                mpq_pkg::REQ_ERASE:
                begin
                    priority if (run_reg == '0)
                    begin
                        code_now = mpq_pkg::STS_ZEROPOS;
                    end
                    else if (32'(run_reg) > 32'(total_reg))
                    begin
                        code_now = mpq_pkg::STS_NONE;
                    end
                    else
                    begin
                        code_now = mpq_pkg::STS_OK;
                    end
                end
                mpq_pkg::REQ_IGNORE:
                begin
                    code_now = mpq_pkg::STS_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        sts.proceed  = (code_now == mpq_pkg::STS_OK) && (req_reg != mpq_pkg::REQ_IGNORE);
        sts.is_add   = (req_reg == mpq_pkg::REQ_ADD);
        sts.lvl_last = (lidx_reg == pri_lvl);
        sts.at_pos   = (idx_reg == acc_reg);
        sts.rm_end   = (32'(idx_reg) + 32'd1) >= 32'(total_reg);
    end

    // store port control
    always_comb
    begin
        unique case (cmd.rd_sel)
            mpq_pkg::RD_CUR:  ra32 = 32'(idx_reg);
            mpq_pkg::RD_PREV: ra32 = 32'(idx_reg) - 32'd1;
            mpq_pkg::RD_NEXT: ra32 = 32'(idx_reg) + 32'd1;
            default:          ra32 = 32'(idx_reg);
        endcase
    end

    assign mem_ra = ra32[AW-1:0];
    assign mem_wa = idx_reg[AW-1:0];
    assign mem_we = cmd.wr_shift || cmd.wr_new;
    assign mem_wd = cmd.wr_new ? {pri_lvl, pay_reg} : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // level counts: each counter updates in place
    always_comb
    begin
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            cnt_next[l] = cnt_reg[l];
            priority if (cfg_load)
            begin
                cnt_next[l] = '0;
            end
            else if (cmd.add_commit && (LW'(l) == pri_lvl))
            begin
                cnt_next[l] = cnt_reg[l] + 1'b1;
            end
            else if (cmd.take && (LW'(l) == rd_lvl) && (cnt_reg[l] != '0))
            begin
                cnt_next[l] = cnt_reg[l] - 1'b1;
            end
            else
            begin
                cnt_next[l] = cnt_reg[l];
            end
        end
    end

    always_comb
    begin
        levels_next = cfg_load ? sat32[LVW-1:0] : levels_reg;

        total_next = total_reg;
        priority if (cfg_load)
        begin
            total_next = '0;
        end
        else if (cmd.add_commit)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (cmd.rm_commit)
        begin
            total_next = total_reg - 1'b1;
        end
        else
        begin
            total_next = total_reg;
        end

        acc_next  = acc_reg;
        lidx_next = lidx_reg;
        if (cmd.acc_init)
        begin
            acc_next  = '0;
            lidx_next = lev_m1[LW-1:0];
        end
        else if (cmd.acc_step)
        begin
            acc_next  = acc_reg + cnt_reg[lidx_reg];
            lidx_next = lidx_reg - 1'b1;
        end

        idx_next = idx_reg;
        priority if (cmd.idx_load_total)
        begin
            idx_next = total_reg;
        end
        else if (cmd.idx_load_rm)
        begin
            idx_next = (req_reg == mpq_pkg::REQ_NEXT) ? '0 : run_m1[CW-1:0];
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end

        code_next  = cmd.latch_code ? code_now : code_reg;
        taken_next = cmd.take ? rd_data_reg[PW-1:0] : taken_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
            total_reg  <= '0;
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                cnt_reg[l] <= '0;
            end
            done_reg   <= 1'b0;
        end
        else
        begin
            levels_reg <= levels_next;
            total_reg  <= total_next;
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                cnt_reg[l] <= cnt_next[l];
            end
            done_reg   <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        lidx_reg  <= lidx_next;
        idx_reg   <= idx_next;
        code_reg  <= code_next;
        taken_reg <= taken_next;
    end

    // result registers
    assign tot_ext = {{TW{1'b0}}, total_reg};

    always_comb
    begin
        pay_out_next = '0;
        if (code_reg == mpq_pkg::STS_OK &&
            (req_reg == mpq_pkg::REQ_NEXT || req_reg == mpq_pkg::REQ_ERASE))
        begin
            pay_out_next = taken_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg  <= code_reg;
            pay_out_reg <= pay_out_next;
            tot_out_reg <= tot_ext[TW-1:0];
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign payload_out = pay_out_reg;
    assign entry_total = tot_out_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_commit |=> (total_reg == $past(total_reg) + 1'b1))
        else $error("add did not increment entry count");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(idx_reg) < 32'(CAPACITY)))
        else $error("store write beyond capacity");

endmodule

`default_nettype wire

### sv/multilevel_priority_queue.sv
// Multilevel priority queue, FIFO per level; depends on mpq_pkg, mpq_ctrl, mpq_datapath.
// Request steps to done: add decodes, sums the level counts, shifts entries and puts the new one;
// next/erase decode, read, take and shift entries; an error or ignored request goes decode, finish.
// Each entry moved takes a check, a read and a write; one request at a
// time, the next one accepted at the end of the done cycle.
// Reset empties the queue and clears levels (not initialized); results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_priority_queue #(
    parameter int MAX_LEVELS = mpq_pkg::MAX_LEVELS,
    parameter int CAPACITY   = mpq_pkg::CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [mpq_pkg::REQ_W-1:0]         req_type,
    input  wire logic [mpq_pkg::PRI_W-1:0]         priority_req,
    input  wire logic [mpq_pkg::PAYLOAD_BITS-1:0]  payload,
    input  wire logic [mpq_pkg::RUN_W-1:0]         running_number,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mpq_pkg::CFG_W-1:0]         cfg_data,
    output logic                                   done,
    output logic [mpq_pkg::STATUS_W-1:0]           status,
    output logic [mpq_pkg::PAYLOAD_BITS-1:0]       payload_out,
    output logic [mpq_pkg::TOTAL_W-1:0]            entry_total
);

    mpq_pkg::dp_cmd_t cmd;
    mpq_pkg::dp_sts_t sts;
    logic             busy_int;

    assign busy      = busy_int;
    assign cfg_ready = !busy_int;

    mpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy_int),
        .cmd   (cmd)
    );

    mpq_datapath #(
        .MAX_LEVELS (MAX_LEVELS),
        .CAPACITY   (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .priority_req   (priority_req),
        .payload        (payload),
        .running_number (running_number),
        .cfg_we         (cfg_valid && !busy_int),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .payload_out    (payload_out),
        .entry_total    (entry_total)
    );

endmodule

`default_nettype wire
